// ===== design/lfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared widths, constants, register codes and inter-module types of the
// line follower position/PID step block.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int SENSOR_COUNT      = 5;
    localparam int FRAC_BITS_DEFAULT = 8;

    localparam int SAMPLE_W   = 16;
    localparam int CLAMP_W    = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int SCALE_FULL = 1000;
    localparam int LANE_P_W   = 22;   // 4095 * 1000 fits in 22 bits

    localparam int THR_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 25;
    localparam int ERR_OUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam int WEIGHT_W   = 4;
    localparam int WSUM_W     = 5;
    localparam int MAG_W      = 4;
    localparam int CNT_W      = 3;
    localparam int ACC_W      = 36;

    localparam logic signed [WEIGHT_W-1:0] SENSOR_WEIGHT [SENSOR_COUNT] =
        '{-4'sd5, -4'sd3, 4'sd1, 4'sd3, 4'sd5};

    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd1024;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd3072;
    localparam logic [THR_W-1:0]  THR_RST       = 10'd890;
    localparam logic [DUTY_W-1:0] DUTY_BASE_RST = 25'd15625000;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 25'd7812500;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 25'd31250000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_DUTY_BASE = 3'd4,
        REG_DUTY_MIN  = 3'd5,
        REG_DUTY_MAX  = 3'd6
    } t_cfg_idx;

    // threshold test as seen by every lane
    typedef struct packed {
        logic                never;   // threshold 1000 or more
        logic [LANE_P_W-1:0] limit;   // (1000 - threshold) * 4095
    } t_thr;

    typedef struct packed {
        logic             lost;
        logic             neg;        // weightsum - 1 is negative
        logic [MAG_W-1:0] mag;        // |weightsum - 1|
        logic [CNT_W-1:0] count;
    } t_merge;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0] duty_base;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
    } t_pid_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0]           left_duty;
        logic [DUTY_W-1:0]           right_duty;
        logic                        line_lost;
        logic signed [ERR_OUT_W-1:0] scaled_error;
    } t_result;

endpackage
`default_nettype wire

// ===== design/lfp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_lane
// One sensor lane: saturate the raw sample, scale it and test the inverted
// reading against the on-line threshold. Registered on-line flag.
// ----------------------------------------------------------------------------
module lfp_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [lfp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire lfp_pkg::t_thr                i_thr,
    output logic                              o_on
);
    import lfp_pkg::*;

    logic [CLAMP_W-1:0]  x;
    logic [LANE_P_W-1:0] p;
    logic                on;
    logic                r_on;

    // 1000 - x*1000/4095 > thr  <=>  x*1000 < (1000 - thr) * 4095
    always_comb begin
        x  = (i_sample > SAMPLE_W'(SAMPLE_MAX)) ? CLAMP_W'(SAMPLE_MAX) : i_sample[CLAMP_W-1:0];
        p  = LANE_P_W'(x) * LANE_P_W'(SCALE_FULL);
        on = !i_thr.never && (p < i_thr.limit);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_on <= on;
        end
    end

    assign o_on = r_on;

endmodule
`default_nettype wire

// ===== design/lfp_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_merge
// Combines the lane flags: weighted sum, on-line count, and the sign and
// magnitude of the position numerator.
// ----------------------------------------------------------------------------
module lfp_merge (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [lfp_pkg::SENSOR_COUNT-1:0] i_on,
    output lfp_pkg::t_merge                       o_merge
);
    import lfp_pkg::*;

    logic signed [WSUM_W-1:0] wsum;
    logic signed [WSUM_W-1:0] wsum_m1;
    logic [CNT_W-1:0]         cnt;
    t_merge                   n_merge;
    t_merge                   r_merge;

    always_comb begin
        wsum = '0;
        cnt  = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_on[i]) begin
                wsum = wsum + WSUM_W'(SENSOR_WEIGHT[i]);
                cnt  = cnt + 1'b1;
            end
        end
        wsum_m1       = wsum - 5'sd1;
        n_merge.lost  = (cnt == '0);
        n_merge.neg   = wsum_m1[WSUM_W-1];
        n_merge.mag   = wsum_m1[WSUM_W-1] ? MAG_W'(-wsum_m1) : MAG_W'(wsum_m1);
        n_merge.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_merge <= n_merge;
        end
    end

    assign o_merge = r_merge;

endmodule
`default_nettype wire

// ===== design/lfp_pid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_pid
// Sequencer for position division, error scaling, integral clamp, the PID
// sum on one shared multiplier and the saturated motor duties.
// ----------------------------------------------------------------------------
module lfp_pid #(
    parameter int FRAC_BITS = lfp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_take,
    input  wire lfp_pkg::t_merge   i_merge,
    input  wire lfp_pkg::t_pid_cfg i_cfg,
    output logic                   o_done,
    output lfp_pkg::t_result       o_result
);
    import lfp_pkg::*;

    localparam int NUM_W   = FRAC_BITS + MAG_W;
    localparam int K       = NUM_W + 3;          // exact for divisors up to 8
    localparam int RCP_W   = K + 1;
    localparam int PROD_W  = NUM_W + RCP_W;
    localparam int ERR_W   = NUM_W + 2;
    localparam int ERR10_W = ERR_W + 4;
    localparam int MUL_W   = GAIN_W + 1 + 17;
    localparam int DS_W    = ACC_W + 1;
    localparam int LIM_INT = ((30 << FRAC_BITS) > 32767) ? 32767 : (30 << FRAC_BITS);

    localparam logic [RCP_W-1:0] RCP1 = RCP_W'(1 << K);
    localparam logic [RCP_W-1:0] RCP2 = RCP_W'(1 << (K - 1));
    localparam logic [RCP_W-1:0] RCP3 = RCP_W'(((1 << K) + 2) / 3);
    localparam logic [RCP_W-1:0] RCP4 = RCP_W'(1 << (K - 2));
    localparam logic [RCP_W-1:0] RCP5 = RCP_W'(((1 << K) + 4) / 5);

    localparam logic signed [ERR_W-1:0]   HALF5    = ERR_W'(5 << (FRAC_BITS - 1));
    localparam logic signed [ERR10_W-1:0] SAT_HI   = ERR10_W'(32767);
    localparam logic signed [ERR10_W-1:0] SAT_LO   = ERR10_W'(-32768);
    localparam logic signed [16:0]        LIM      = 17'(LIM_INT);
    localparam logic signed [ACC_W-1:0]   ROUND    = ACC_W'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
    localparam logic signed [ACC_W-1:0]   ZERO_ACC = '0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ERR, ST_MP, ST_MI, ST_MD, ST_SHIFT, ST_DUTY, ST_DONE
    } t_state;

    t_state                       r_state;
    logic [PROD_W-1:0]            r_prod;
    logic signed [ERR_OUT_W-1:0]  r_last;
    logic signed [ERR_OUT_W-1:0]  r_esum;
    logic signed [ERR_OUT_W-1:0]  r_scaled;
    logic signed [16:0]           r_diff;
    logic                         r_lost;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      r_corr;
    logic [DUTY_W-1:0]            r_left;
    logic [DUTY_W-1:0]            r_right;

    logic [NUM_W-1:0]             num;
    logic [RCP_W-1:0]             rcp;
    logic [PROD_W-1:0]            n_prod;
    logic [NUM_W-1:0]             quo;
    logic signed [ERR_W-1:0]      quo_s;
    logic signed [ERR_W-1:0]      err;
    logic signed [ERR10_W-1:0]    err10;
    logic signed [ERR_OUT_W-1:0]  n_scaled;
    logic signed [16:0]           n_diff;
    logic signed [16:0]           sum_raw;
    logic signed [ERR_OUT_W-1:0]  n_esum;
    logic signed [GAIN_W:0]       m_gain;
    logic signed [16:0]           m_op;
    logic signed [MUL_W-1:0]      m_prod;
    logic signed [ACC_W-1:0]      n_acc;
    logic signed [ACC_W-1:0]      n_corr;
    logic signed [DS_W-1:0]       base_s;
    logic signed [DS_W-1:0]       min_s;
    logic signed [DS_W-1:0]       max_s;
    logic signed [DS_W-1:0]       corr_s;
    logic signed [DS_W-1:0]       left_s;
    logic signed [DS_W-1:0]       right_s;
    logic [DUTY_W-1:0]            n_left;
    logic [DUTY_W-1:0]            n_right;

    // position division: multiply by a reciprocal of the small count
    always_comb begin
        num = {i_merge.mag, FRAC_BITS'(0)};
        unique case (i_merge.count)
            3'd1:    rcp = RCP1;
            3'd2:    rcp = RCP2;
            3'd3:    rcp = RCP3;
            3'd4:    rcp = RCP4;
            3'd5:    rcp = RCP5;
            default: rcp = '0;
        endcase
        n_prod = PROD_W'(num) * PROD_W'(rcp);
    end

    // error, scaling, derivative and clamped integral
    always_comb begin
        quo   = r_prod[K +: NUM_W];
        quo_s = ERR_W'(quo);
        if (i_merge.lost) begin
            err = (r_last > 16'sd0) ? HALF5 : -HALF5;
        end else begin
            err = i_merge.neg ? -quo_s : quo_s;
        end
        err10 = (ERR10_W'(err) <<< 3) + (ERR10_W'(err) <<< 1);
        if (err10 > SAT_HI) begin
            n_scaled = ERR_OUT_W'(SAT_HI);
        end else if (err10 < SAT_LO) begin
            n_scaled = ERR_OUT_W'(SAT_LO);
        end else begin
            n_scaled = err10[ERR_OUT_W-1:0];
        end
        n_diff  = 17'(n_scaled) - 17'(r_last);
        sum_raw = 17'(r_esum) + 17'(n_scaled);
        if (sum_raw > LIM) begin
            n_esum = ERR_OUT_W'(LIM);
        end else if (sum_raw < -LIM) begin
            n_esum = ERR_OUT_W'(-LIM);
        end else begin
            n_esum = sum_raw[ERR_OUT_W-1:0];
        end
    end

    // one multiplier shared by the three PID terms
    always_comb begin
        unique case (r_state)
            ST_MI: begin
                m_gain = signed'({1'b0, i_cfg.gain_i});
                m_op   = 17'(r_esum);
            end
            ST_MD: begin
                m_gain = signed'({1'b0, i_cfg.gain_d});
                m_op   = r_diff;
            end
            default: begin
                m_gain = signed'({1'b0, i_cfg.gain_p});
                m_op   = 17'(r_scaled);
            end
        endcase
        m_prod = MUL_W'(m_gain) * MUL_W'(m_op);
        n_acc  = ((r_state == ST_MP) ? ZERO_ACC : r_acc) + ACC_W'(m_prod);
        // truncate toward zero: bias negatives before the arithmetic shift
        n_corr = (r_acc + (r_acc[ACC_W-1] ? ROUND : ZERO_ACC)) >>> (2 * FRAC_BITS);
    end

    // duty = base +/- corr; lower bound first, then upper
    always_comb begin
        base_s  = DS_W'(i_cfg.duty_base);
        min_s   = DS_W'(i_cfg.duty_min);
        max_s   = DS_W'(i_cfg.duty_max);
        corr_s  = DS_W'(r_corr);
        left_s  = base_s + corr_s;
        right_s = base_s - corr_s;
        if (left_s < min_s) begin
            n_left = i_cfg.duty_min;
        end else if (left_s > max_s) begin
            n_left = i_cfg.duty_max;
        end else begin
            n_left = left_s[DUTY_W-1:0];
        end
        if (right_s < min_s) begin
            n_right = i_cfg.duty_min;
        end else if (right_s > max_s) begin
            n_right = i_cfg.duty_max;
        end else begin
            n_right = right_s[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= '0;
            r_esum  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_prod  <= n_prod;
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    r_scaled <= n_scaled;
                    r_diff   <= n_diff;
                    r_lost   <= i_merge.lost;
                    r_last   <= n_scaled;
                    r_esum   <= n_esum;
                    r_state  <= ST_MP;
                end
                ST_MP: begin
                    r_acc   <= n_acc;
                    r_state <= ST_MI;
                end
                ST_MI: begin
                    r_acc   <= n_acc;
                    r_state <= ST_MD;
                end
                ST_MD: begin
                    r_acc   <= n_acc;
                    r_state <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    r_corr  <= n_corr;
                    r_state <= ST_DUTY;
                end
                ST_DUTY: begin
                    r_left  <= n_left;
                    r_right <= n_right;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done                = (r_state == ST_DONE);
    assign o_result.left_duty    = r_left;
    assign o_result.right_duty   = r_right;
    assign o_result.line_lost    = r_lost;
    assign o_result.scaled_error = r_scaled;

endmodule
`default_nettype wire

// ===== design/line_follow_pid_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pid_step_top
// One control step of a five-sensor line follower: weighted line position,
// PID correction and saturated left/right motor duties.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one item carries five 16-bit raw sensor samples. Output
//   stream: one result item per input item (left/right duty, scaled error,
//   line-lost flag in tuser).
//   Config channel: write register index and data; always ready. Write only
//   while no item is in flight.
//   Five sensor lanes test the samples in parallel, a merge stage forms the
//   weighted sum and count, then a sequencer runs the division and the PID
//   terms on one shared multiplier, one step per cycle.
//   Path: lane flags, merge register, sequencer states IDLE, ERR, MP, MI,
//   MD, SHIFT, DUTY and DONE, then the output register. One item is in
//   flight at a time; the next item is taken once a result enters the
//   output register, even while that result still waits for i_m_tready.
//   Receiver stall: the result holds in the output register; a finished
//   item behind it waits in the sequencer and input stays blocked.
//   Reset: registers return to their default values, last error and error
//   sum clear to zero, no item in flight.
// ----------------------------------------------------------------------------
module line_follow_pid_step_top #(
    parameter int FRAC_BITS = lfp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample_0[15:0], sample_1[31:16], sample_2[47:32], sample_3[63:48],
    // sample_4[79:64]
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [79:0]                    i_s_tdata,
    // left_duty[24:0], right_duty[49:25], scaled_error[65:50], zero pad
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [71:0]                         o_m_tdata,
    // line_lost[0]
    output logic [0:0]                          o_m_tuser,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lfp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lfp_pkg::*;

    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [THR_W-1:0]  r_thr;
    logic [DUTY_W-1:0] r_duty_base;
    logic [DUTY_W-1:0] r_duty_min;
    logic [DUTY_W-1:0] r_duty_max;

    logic              r_busy;
    logic              r_lane_vld;
    logic              r_merge_vld;
    logic              r_out_vld;
    logic [71:0]       r_out_data;
    logic              r_out_lost;

    logic              s_accept;
    logic              cfg_we;
    logic              pid_done;
    logic              pid_take;
    logic [THR_W-1:0]  thr_k;
    t_thr              thr;
    t_merge            merge;
    t_pid_cfg          pid_cfg;
    t_result           result;
    logic [SENSOR_COUNT-1:0] lane_on;

    assign o_s_tready  = !r_busy;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_thr       <= THR_RST;
            r_duty_base <= DUTY_BASE_RST;
            r_duty_min  <= DUTY_MIN_RST;
            r_duty_max  <= DUTY_MAX_RST;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                REG_THRESHOLD: r_thr       <= i_cfg_data[THR_W-1:0];
                REG_DUTY_BASE: r_duty_base <= i_cfg_data[DUTY_W-1:0];
                REG_DUTY_MIN:  r_duty_min  <= i_cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX:  r_duty_max  <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // threshold as a bound on x*1000, shared by all lanes
    always_comb begin
        thr_k     = THR_W'(SCALE_FULL) - r_thr;
        thr.never = (r_thr >= THR_W'(SCALE_FULL));
        thr.limit = {thr_k, 12'b0} - LANE_P_W'(thr_k);
    end

    assign pid_cfg.gain_p    = r_gain_p;
    assign pid_cfg.gain_i    = r_gain_i;
    assign pid_cfg.gain_d    = r_gain_d;
    assign pid_cfg.duty_base = r_duty_base;
    assign pid_cfg.duty_min  = r_duty_min;
    assign pid_cfg.duty_max  = r_duty_max;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lfp_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (s_accept),
            .i_sample (i_s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .i_thr    (thr),
            .o_on     (lane_on[g])
        );
    end

    lfp_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (r_lane_vld),
        .i_on    (lane_on),
        .o_merge (merge)
    );

    lfp_pid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_merge_vld),
        .i_take   (pid_take),
        .i_merge  (merge),
        .i_cfg    (pid_cfg),
        .o_done   (pid_done),
        .o_result (result)
    );

    assign pid_take = pid_done && (!r_out_vld || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_lane_vld  <= 1'b0;
            r_merge_vld <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_lane_vld  <= s_accept;
            r_merge_vld <= r_lane_vld;
            if (s_accept) begin
                r_busy <= 1'b1;
            end else if (pid_take) begin
                r_busy <= 1'b0;
            end
            if (pid_take) begin
                r_out_vld  <= 1'b1;
                r_out_data <= {6'b0, result.scaled_error, result.right_duty,
                               result.left_duty};
                r_out_lost <= result.line_lost;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_lost;

`ifndef NO_ASSERTIONS
    // only one item moves through lanes, merge and sequencer at a time
    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_accept, r_lane_vld, r_merge_vld, pid_done}))
        else $error("more than one item in flight");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merge_vld |-> r_busy)
        else $error("sequencer started with no item accepted");

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pid_take |=> (r_out_vld && !r_busy))
        else $error("result not loaded into output register");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line follower position/PID step block.
// Sensor frames go in on the input stream under a series of register
// settings; a scoreboard predicts each motor duty result and compares it
// field by field with the output stream. Both sides idle at random, the
// receiver stalls for a long stretch once, and the sender drains once.
// ----------------------------------------------------------------------------
module tb;
    import lfp_pkg::*;

    localparam int F           = FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 12;     // margin past the block's latency
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int EDGE_SPAN   = 40000;  // about half the widest correction

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [DUTY_W-1:0]    DUTY_TOP   = 25'h1FFFFFF;
    localparam logic [SAMPLE_W-1:0]  RAW_TOP    = 16'hFFFF;
    localparam logic [GAIN_W-1:0]    GAIN_TOP   = 16'hFFFF;

    class pid_steer_checker;
        int gain_p, gain_i, gain_d, threshold;
        longint duty_base, duty_min, duty_max;
        int last_err, err_sum;
        t_result steer_q[$];
        int mismatches, frames, results, lost_frames;

        function new();
            gain_p      = int'(GAIN_P_RST);
            gain_i      = int'(GAIN_I_RST);
            gain_d      = int'(GAIN_D_RST);
            threshold   = int'(THR_RST);
            duty_base   = longint'(DUTY_BASE_RST);
            duty_min    = longint'(DUTY_MIN_RST);
            duty_max    = longint'(DUTY_MAX_RST);
            last_err    = 0;
            err_sum     = 0;
            mismatches  = 0;
            frames      = 0;
            results     = 0;
            lost_frames = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GAIN_P:    gain_p    = int'(val[GAIN_W-1:0]);
                REG_GAIN_I:    gain_i    = int'(val[GAIN_W-1:0]);
                REG_GAIN_D:    gain_d    = int'(val[GAIN_W-1:0]);
                REG_THRESHOLD: threshold = int'(val[THR_W-1:0]);
                REG_DUTY_BASE: duty_base = longint'(val[DUTY_W-1:0]);
                REG_DUTY_MIN:  duty_min  = longint'(val[DUTY_W-1:0]);
                REG_DUTY_MAX:  duty_max  = longint'(val[DUTY_W-1:0]);
                default: ;
            endcase
        endfunction

        function int clip16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // lower bound wins first, so min above max yields min on underflow
        function logic [DUTY_W-1:0] bound(longint v);
            if (v < duty_min) v = duty_min;
            else if (v > duty_max) v = duty_max;
            return v[DUTY_W-1:0];
        endfunction

        function void note_frame(logic [SENSOR_COUNT*SAMPLE_W-1:0] d);
            int unsigned raw, inv;
            int wsum, cnt, err, scaled, diff, acc, lim, k;
            longint corr;
            t_result r;
            wsum = 0;
            cnt  = 0;
            for (k = 0; k < SENSOR_COUNT; k++) begin
                raw = 32'(d[k*SAMPLE_W +: SAMPLE_W]);
                if (raw > SAMPLE_MAX) raw = SAMPLE_MAX;
                inv = SCALE_FULL - raw * SCALE_FULL / SAMPLE_MAX;
                if (inv > threshold) begin
                    wsum += int'(SENSOR_WEIGHT[k]);
                    cnt++;
                end
            end
            if (cnt == 0) err = (last_err > 0) ? (5 << (F - 1)) : -(5 << (F - 1));
            else err = ((wsum - 1) * (1 << F)) / cnt;
            scaled = clip16(err * 10);
            diff   = scaled - last_err;
            lim    = clip16(30 << F);
            acc    = err_sum + scaled;
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            err_sum = acc;
            corr = longint'(gain_p) * scaled + longint'(gain_i) * err_sum
                 + longint'(gain_d) * diff;
            corr = (corr < 0) ? -((-corr) >> (2 * F)) : (corr >> (2 * F));
            last_err = scaled;
            r.left_duty    = bound(duty_base + corr);
            r.right_duty   = bound(duty_base - corr);
            r.line_lost    = (cnt == 0);
            r.scaled_error = scaled[ERR_OUT_W-1:0];
            steer_q.push_back(r);
            frames++;
        endfunction

        function void check_result(logic [71:0] d, logic lost);
            t_result want, got;
            got.left_duty    = d[DUTY_W-1:0];
            got.right_duty   = d[2*DUTY_W-1:DUTY_W];
            got.scaled_error = d[2*DUTY_W +: ERR_OUT_W];
            got.line_lost    = lost;
            results++;
            if (lost) lost_frames++;
            if (steer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: left %0d right %0d err %0d lost %0b",
                             got.left_duty, got.right_duty, got.scaled_error, got.line_lost);
                return;
            end
            want = steer_q.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d (exp/act): left %0d/%0d right %0d/%0d",
                              " err %0d/%0d lost %0b/%0b"},
                             results, want.left_duty, got.left_duty, want.right_duty,
                             got.right_duty, want.scaled_error, got.scaled_error,
                             want.line_lost, got.line_lost);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic [79:0]           s_tdata    = '0;
    logic                  m_tready   = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  tx_idle_on = 1'b1;
    logic                  rx_idle_on = 1'b1;
    int                    stall_token = 0;
    int                    settings    = 0;
    int                    cycles      = 0;

    wire        s_tready;
    wire        m_tvalid;
    wire [71:0] m_tdata;
    wire [0:0]  m_tuser;
    wire        cfg_ready;

    pid_steer_checker chk;

    line_follow_pid_step_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, chk.steer_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random idling plus one long hold-off on request
    int hold_left  = 0;
    int stall_seen = 0;
    always @(posedge clk) begin
        if (rst_n && m_tready && m_tvalid) chk.check_result(m_tdata, m_tuser[0]);
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < 32);
        end
    end

    function automatic logic [79:0] frame5(logic [15:0] s0, s1, s2, s3, s4);
        return {s4, s3, s2, s1, s0};
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return GAIN_TOP;
        if (r == 2) return GAIN_W'($urandom_range(65535));
        return GAIN_W'($urandom_range(4096));
    endfunction

    task automatic send_frame(logic [79:0] d);
        while (tx_idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        chk.note_frame(d);
    endtask

    // no result in flight, then a settling margin
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (chk.steer_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        chk.set_reg(idx, val);
    endtask

    task automatic load_config(logic [GAIN_W-1:0] gp, gi, gd, logic [THR_W-1:0] thr,
                               logic [DUTY_W-1:0] base, lo, hi);
        write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
        write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
        write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_DUTY_BASE, base);
        write_reg(REG_DUTY_MIN, lo);
        write_reg(REG_DUTY_MAX, hi);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        int n, k, c, w, kind, phase;
        logic [79:0] fr;
        logic [DUTY_W-1:0] base, lo, hi, tmp;
        logic [THR_W-1:0] thr;
        chk = new();
        settings = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: lost with zero history, centered, both ends, lost after
        // a positive error, a split pair, the threshold edge, saturated samples
        send_frame(frame5(RAW_TOP, RAW_TOP, RAW_TOP, RAW_TOP, RAW_TOP));
        send_frame(frame5(0, 0, 0, 0, 0));
        send_frame(frame5(4096, 4096, 4096, 4096, 0));
        send_frame(frame5(RAW_TOP, 4096, 4095, RAW_TOP, 4097));
        send_frame(frame5(0, 4095, 4095, 4095, RAW_TOP));
        send_frame(frame5(4095, 0, 0, 4096, 4095));
        send_frame(frame5(450, 451, 450, 451, 450));
        send_frame(frame5(16'h5555, 16'hAAAA, 16'h0AAA, 16'h0555, 16'hFFFF));
        wait_idle();

        // an out-of-range index must change nothing
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(33554431)));
        // full gains, threshold zero, widest duty range
        load_config(GAIN_TOP, GAIN_TOP, GAIN_TOP, '0, '0, '0, DUTY_TOP);
        send_frame(frame5(4095, 4094, 4095, 4095, 4095));
        send_frame(frame5(0, 4095, 4095, 4095, 4095));
        send_frame(frame5(4095, 4095, 4095, 4095, 4095));
        send_frame(frame5(0, 0, 0, 0, 4095));
        wait_idle();

        // threshold 1000 never sees the line; min above max with zero gains
        load_config('0, '0, '0, 10'd1000, DUTY_TOP, 25'd20000000, 25'd10000000);
        send_frame(frame5(0, 0, 0, 0, 0));
        send_frame(frame5(RAW_TOP, 0, RAW_TOP, 0, RAW_TOP));
        send_frame(frame5(0, 4095, 0, 4095, 0));
        wait_idle();

        // zero base with min above max: underflow lands on the lower bound
        load_config(GAIN_TOP, '0, '0, 10'd890, '0, 25'd5000000, 25'd1000000);
        send_frame(frame5(0, 4095, 4095, 4095, 4095));
        send_frame(frame5(4095, 4095, 4095, 4095, 0));
        send_frame(frame5(4095, 4095, 0, 4095, 4095));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            base = DUTY_W'($urandom_range(33554431));
            if ($urandom_range(3) == 0 && base > EDGE_SPAN)
                lo = base - DUTY_W'($urandom_range(EDGE_SPAN));
            else lo = DUTY_W'($urandom_range(base));
            if ($urandom_range(3) == 0 && base < DUTY_TOP - EDGE_SPAN)
                hi = base + DUTY_W'($urandom_range(EDGE_SPAN));
            else hi = DUTY_W'($urandom_range(DUTY_TOP, base));
            if ($urandom_range(7) == 0) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            thr = ($urandom_range(5) == 0) ? THR_W'($urandom_range(1000))
                                            : THR_W'($urandom_range(980, 780));
            load_config(pick_gain(), pick_gain(), pick_gain(), thr, base, lo, hi);
            tx_idle_on <= (phase != 3);
            rx_idle_on <= (phase != 3);
            if (phase == 2) stall_token <= stall_token + 1;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(99);
                c    = $urandom_range(SENSOR_COUNT - 1);
                w    = $urandom_range(1);
                for (k = 0; k < SENSOR_COUNT; k++) begin
                    if (kind < 60)
                        fr[k*SAMPLE_W +: SAMPLE_W] = (k == c || (w != 0 && k == c + 1))
                            ? SAMPLE_W'($urandom_range(500))
                            : SAMPLE_W'($urandom_range(4095, 1500));
                    else if (kind < 70)
                        fr[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(4095, 3000));
                    else if (kind < 85)
                        fr[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(4095));
                    else
                        fr[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(65535));
                end
                // sender holds back once until the pipe is empty
                if (phase == 5 && n == PHASE_ITEMS / 2) wait_idle();
                send_frame(fr);
            end
        end
        wait_idle();

        $display("Covered %0d sensor frames and %0d checked results over %0d register settings,",
                 chk.frames, chk.results, settings);
        $display("%0d frames with the line lost, plus one long output stall and one drain pause.",
                 chk.lost_frames);
        if (chk.mismatches == 0 && chk.steer_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
